[hw/rtl/hsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsp_pkg
// Shared types, constants and pattern helpers for the Horspool search block.
// ----------------------------------------------------------------------------
package hsp_pkg;

  localparam int TEXT_DEPTH_DEF = 1024;
  localparam int MAX_PATTERN    = 16;
  localparam int PAT_BYTES      = 16;
  localparam int LEN_W          = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LEN  = 2'd0,
    CFG_PATTERN_LOW  = 2'd1,
    CFG_PATTERN_HIGH = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
  } in_item_t;

  typedef struct packed {
    logic found;
    logic text_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic store;
    logic init;
    logic advance;
    logic skip;
    logic set_found;
    logic clr_found;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic short_text;
    logic match;
    logic last_cmp;
    logic skip_ok;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] pat_byte(input logic [8*PAT_BYTES-1:0] pat,
                                          input logic [3:0] idx);
    pat_byte = pat[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [LEN_W-1:0] shift_of(input logic [7:0] b,
                                                input logic [8*PAT_BYTES-1:0] pat,
                                                input logic [LEN_W-1:0] m);
    logic [LEN_W-1:0] s;
    s = m;
    for (int i = 0; i < PAT_BYTES - 1; i++) begin
      if (((LEN_W'(i) + LEN_W'(1)) < m) && (pat[i*8 +: 8] == b)) begin
        s = m - LEN_W'(1) - LEN_W'(i);
      end
    end
    shift_of = s;
  endfunction

endpackage

[hw/rtl/hsp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/hsp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsp_ctrl
// Sequencer: text loading, right-to-left compare, skip and result hand-off.
// ----------------------------------------------------------------------------
module hsp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  hsp_pkg::sts_t sts,
  output hsp_pkg::cmd_t cmd
);

  import hsp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last) state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = sts.short_text ? ST_DONE : ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (sts.match && sts.last_cmp) begin
          state_nxt = ST_DONE;
        end else if (sts.match || sts.skip_ok) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready  = 1'b1;
        cmd.store = in_valid;
      end
      ST_START: begin
        cmd.init      = !sts.short_text;
        cmd.clr_found = sts.short_text;
      end
      ST_READ: begin
      end
      ST_CMP: begin
        if (sts.match && sts.last_cmp) begin
          cmd.set_found = 1'b1;
        end else if (sts.match) begin
          cmd.advance = 1'b1;
        end else begin
          cmd.skip      = 1'b1;
          cmd.clr_found = !sts.skip_ok;
        end
      end
      ST_DONE: begin
        cmd.publish = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/hsp_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsp_dp
// Datapath: pattern registers, text store, search pointers and result register.
// ----------------------------------------------------------------------------
module hsp_dp #(
  parameter int TEXT_DEPTH = hsp_pkg::TEXT_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [hsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hsp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  hsp_pkg::in_item_t                in_data,
  input  hsp_pkg::cmd_t                    cmd,
  output hsp_pkg::sts_t                    sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output hsp_pkg::out_item_t               out_data
);

  import hsp_pkg::*;

  localparam int AW = $clog2(TEXT_DEPTH);
  localparam int CW = $clog2(TEXT_DEPTH + 1);

  logic [LEN_W-1:0]       pat_len_r;
  logic [CFG_DATA_W-1:0]  pat_low_r;
  logic [CFG_DATA_W-1:0]  pat_high_r;
  logic [8*PAT_BYTES-1:0] pattern;
  logic [LEN_W-1:0]       m;

  logic [CW-1:0]          count_r;
  logic                   ovf_r;
  logic [CW-1:0]          pos_r;
  logic [3:0]             z_r;
  logic [7:0]             tail_r;
  logic                   found_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic                   we;
  logic [AW-1:0]          raddr;
  logic [7:0]             rdata;
  logic [7:0]             tail_byte;
  logic [LEN_W-1:0]       pidx_full;
  logic [CW:0]            skip_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r  <= '0;
      pat_low_r  <= '0;
      pat_high_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PATTERN_LEN:  pat_len_r  <= cfg_data[LEN_W-1:0];
        CFG_PATTERN_LOW:  pat_low_r  <= cfg_data;
        CFG_PATTERN_HIGH: pat_high_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign pattern = {pat_high_r, pat_low_r};
  assign m = (pat_len_r > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_r;

  assign we    = cmd.store && (count_r < CW'(TEXT_DEPTH));
  assign raddr = pos_r[AW-1:0] - AW'(z_r);

  hsp_ram #(
    .WIDTH(8),
    .DEPTH(TEXT_DEPTH)
  ) u_text_ram (
    .clk  (clk),
    .we   (we),
    .waddr(count_r[AW-1:0]),
    .wdata(in_data.text_byte),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign tail_byte = (z_r == 4'd0) ? rdata : tail_r;
  assign pidx_full = m - LEN_W'(1) - LEN_W'(z_r);
  assign skip_sum  = {1'b0, pos_r} + (CW + 1)'(shift_of(tail_byte, pattern, m));

  assign sts.short_text = (m == '0) || (CW'(m) > count_r);
  assign sts.match      = (rdata == pat_byte(pattern, pidx_full[3:0]));
  assign sts.last_cmp   = (LEN_W'(z_r) == (m - LEN_W'(1)));
  assign sts.skip_ok    = (skip_sum < {1'b0, count_r});
  assign sts.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.publish) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.store) begin
      if (we) begin
        count_r <= count_r + CW'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      pos_r <= CW'(m - LEN_W'(1));
      z_r   <= 4'd0;
    end else if (cmd.advance) begin
      z_r <= z_r + 4'd1;
      if (z_r == 4'd0) tail_r <= rdata;
    end else if (cmd.skip) begin
      pos_r <= skip_sum[CW-1:0];
      z_r   <= 4'd0;
    end
    if (cmd.set_found) begin
      found_r <= 1'b1;
    end else if (cmd.clr_found) begin
      found_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data_r.found         <= found_r;
      out_data_r.text_overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/horspool_substring_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// horspool_substring_search
// Reports whether a configured pattern of up to 16 bytes occurs in a text.
// ----------------------------------------------------------------------------
// Usage:
//   Write pattern_len (index 0), pattern_low (1) and pattern_high (2) on the
//   cfg_ channel while the block is idle; cfg_ready is always high.
//   Stream text bytes on the in_ channel, one transaction per cycle, and mark
//   the final byte with text_last. Bytes past TEXT_DEPTH are dropped and the
//   result then carries text_overflow.
//   After the final byte the block stops taking input and runs the search:
//   a start step, then a read step and a compare step per byte compare, since
//   each text byte comes from the text RAM through its registered read port.
//   A done step then hands the result off.
//   The single result (found, text_overflow) sits in an output register; the
//   next text may stream in while it waits, and a following result holds in
//   the controller until the receiver takes the earlier one.
//   Reset clears the pattern registers, the byte count and the output valid.
// ----------------------------------------------------------------------------
module horspool_substring_search #(
  parameter int TEXT_DEPTH = hsp_pkg::TEXT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hsp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hsp_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output hsp_pkg::out_item_t             out_data
);

  import hsp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  hsp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_last (in_data.text_last),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  hsp_dp #(
    .TEXT_DEPTH(TEXT_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.store, cmd.init, cmd.advance, cmd.skip, cmd.publish}))
    else $error("conflicting datapath commands");

  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("result published into an occupied output register");

  a_advance_partial: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> (sts.match && !sts.last_cmp))
    else $error("compare advanced past the pattern");

  a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.text_last) |=> !in_ready)
    else $error("input taken during search");

endmodule
